@@ rtl/softmax_cross_entropy_bpp_defines.svh @@
// Assertion macros used by the top-level module.
`ifndef SOFTMAX_CROSS_ENTROPY_BPP_DEFINES_SVH
`define SOFTMAX_CROSS_ENTROPY_BPP_DEFINES_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define SCE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Checks that an antecedent implies a consequent in the following cycle.
`define SCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/sce_pkg.sv @@
`default_nettype none
package sce_pkg;
    localparam int MaxClasses = 256;
    localparam logic [63:0] Mask48 = 64'hFFFF_FFFF_FFFF;
    localparam logic [63:0] OneQ30 = 64'd1073741824;
    localparam logic [16:0] Log2eQ16 = 17'd94548;

    localparam logic [1:0] REG_POINTS = 2'd0;
    localparam logic [1:0] REG_CLASSES = 2'd1;

    typedef struct packed {
        logic signed [15:0] logit;
        logic [7:0]         target_class;
        logic               last_row;
    } t_in;

    typedef struct packed {
        logic [31:0] row_bits;
        logic [47:0] total_bits;
        logic [31:0] bits_per_point;
        logic        zero_prob;
        logic        done_res;
    } t_out;

    typedef struct packed {
        logic        start;
        logic [2:0]  op;
        logic [63:0] a;
        logic [63:0] b;
    } t_alu_req;

    localparam logic [2:0] OP_MUL = 3'd0;
    localparam logic [2:0] OP_DIV = 3'd1;

    function automatic logic [31:0] exp_coef(input logic [2:0] k);
        logic [31:0] c;
        case (k)
            3'd0: c = 32'd744261118;
            3'd1: c = 32'd257941248;
            3'd2: c = 32'd59597083;
            3'd3: c = 32'd10327388;
            3'd4: c = 32'd1431680;
            3'd5: c = 32'd165394;
            3'd6: c = 32'd16378;
            default: c = 32'd0;
        endcase
        return c;
    endfunction
endpackage
`default_nettype wire

@@ rtl/sce_alu.sv @@
`default_nettype none
// Shared unit: a registered 32x32 multiply, or a restoring divide of a
// 48-bit dividend by a 24-bit divisor at one quotient bit per cycle.
module sce_alu (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire sce_pkg::t_alu_req i_req,
    output logic                 o_done,
    output logic [63:0]          o_res
);
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [47:0] r_quo, n_quo;
    logic [24:0] r_rem, n_rem;
    logic [23:0] r_div, n_div;
    logic [63:0] r_res, n_res;
    logic [24:0] w_sh;

    always_comb begin
        n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0; n_quo = r_quo;
        n_rem = r_rem; n_div = r_div; n_res = r_res;
        w_sh = {r_rem[23:0], r_quo[47]};
        if (i_req.start && i_req.op == sce_pkg::OP_MUL) begin
            n_res = {32'd0, i_req.a[31:0]} * {32'd0, i_req.b[31:0]};
            n_done = 1'b1;
        end else if (i_req.start) begin
            n_quo = i_req.a[47:0]; n_div = i_req.b[23:0];
            n_rem = '0; n_cnt = 6'd48; n_busy = 1'b1;
        end else if (r_busy) begin
            n_quo = {r_quo[46:0], 1'b0};
            if (w_sh >= {1'b0, r_div}) begin
                n_rem = w_sh - {1'b0, r_div};
                n_quo[0] = 1'b1;
            end else begin
                n_rem = w_sh;
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0; n_done = 1'b1;
                n_res = {16'd0, n_quo};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_quo <= n_quo; r_rem <= n_rem; r_div <= n_div; r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule
`default_nettype wire

@@ rtl/softmax_cross_entropy_bpp.sv @@
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_ready   i_in  (sce_pkg::t_in)
// out       output     o_out_valid / i_out_ready o_out (sce_pkg::t_out)
// cfg       input      i_cfg_we                  i_cfg_index, i_cfg_data
// One logit transaction issues eight multiplies on the shared unit, each
// result captured in a wait state, and then scales the exp in S_EXPF.
// A row end adds a log2 pass of 16 squarings for the exp sum, and one for
// a nonzero target exp; the last row adds a divide if points is nonzero.
// Synchronous active-low reset clears FSM and sums, and presets config.
// A waiting result holds the block until it is taken.
`default_nettype none
`include "softmax_cross_entropy_bpp_defines.svh"
module softmax_cross_entropy_bpp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire sce_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output sce_pkg::t_out      o_out,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [23:0]   i_cfg_data
);
    localparam logic [3:0] S_IDLE = 4'd0, S_YMUL = 4'd1, S_HORN = 4'd2,
        S_HWAIT = 4'd3, S_EXPF = 4'd4, S_LSTART = 4'd5, S_LSQ = 4'd6,
        S_LWAIT = 4'd7, S_ROW = 4'd8, S_DIVW = 4'd9, S_OUT = 4'd10;

    logic [3:0]  r_st, n_st;
    logic [23:0] r_points;
    logic [8:0]  r_classes;
    logic [8:0]  r_col, n_col;
    logic [47:0] r_esum, n_esum;
    logic [31:0] r_texp, n_texp;
    logic [47:0] r_ent, n_ent;
    sce_pkg::t_in r_item, n_item;
    logic [63:0] r_p, n_p;
    logic [2:0]  r_k, n_k;
    logic        r_last_mul, n_last_mul;
    logic signed [8:0] r_n, n_n;
    logic [15:0] r_f, n_f;
    logic [63:0] r_m, n_m;
    logic [15:0] r_frac, n_frac;
    logic [4:0]  r_i, n_i;
    logic        r_lsel, n_lsel;
    logic [21:0] r_ls, n_ls;
    logic [31:0] r_rb, n_rb;
    logic        r_zero, n_zero;
    logic [31:0] r_bpp, n_bpp;
    sce_pkg::t_out r_out, n_out;
    logic        r_ov, n_ov;
    sce_pkg::t_alu_req w_req;
    logic        w_adone;
    logic [63:0] w_ares;
    logic [8:0]  w_count;
    logic [63:0] w_yo, w_sq, w_r, w_e, w_src, w_sum, w_ent;
    logic [5:0]  w_k;
    logic [21:0] w_lt, w_lv;

    sce_alu u_alu (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req),
        .o_done(w_adone), .o_res(w_ares));

    assign w_count = (r_classes == 9'd0) ? 9'd1 :
        (r_classes > 9'(sce_pkg::MaxClasses)) ? 9'(sce_pkg::MaxClasses) : r_classes;

    always_comb begin
        w_k = 6'd0;
        w_src = r_lsel ? {32'd0, r_texp} : {16'd0, r_esum};
        for (int j = 0; j < 48; j++) begin
            if (w_src[j]) w_k = 6'(j);
        end
    end

    always_comb begin
        n_st = r_st; n_col = r_col; n_esum = r_esum; n_texp = r_texp;
        n_ent = r_ent; n_item = r_item; n_p = r_p; n_k = r_k;
        n_last_mul = r_last_mul; n_n = r_n; n_f = r_f; n_m = r_m;
        n_frac = r_frac; n_i = r_i; n_lsel = r_lsel; n_ls = r_ls;
        n_rb = r_rb; n_zero = r_zero; n_bpp = r_bpp; n_out = r_out; n_ov = r_ov;
        w_req = '0; w_yo = '0; w_sq = '0; w_r = '0; w_e = '0;
        w_sum = '0; w_ent = '0; w_lt = '0; w_lv = '0;
        if (r_ov && i_out_ready) n_ov = 1'b0;
        case (r_st)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in;
                    w_req.start = 1'b1; w_req.op = sce_pkg::OP_MUL;
                    w_req.a = 64'(unsigned'(32'(signed'(i_in.logit) + 32'sd32768)));
                    w_req.b = {47'd0, sce_pkg::Log2eQ16};
                    n_st = S_YMUL;
                end
            end
            S_YMUL: begin
                if (w_adone) begin
                    // (logit + 32768) * c = logit * c + 32768 * c; remove the bias.
                    w_yo = w_ares - (64'd32768 * 64'd94548) + (64'd256 << 24);
                    n_n = 9'(signed'({1'b0, w_yo[32:24]}) - 10'sd256);
                    n_f = w_yo[23:8];
                    n_p = {32'd0, sce_pkg::exp_coef(3'd6)};
                    n_k = 3'd5; n_last_mul = 1'b0;
                    n_st = S_HORN;
                end
            end
            S_HORN: begin
                w_req.start = 1'b1; w_req.op = sce_pkg::OP_MUL;
                w_req.a = r_p; w_req.b = {48'd0, r_f};
                n_st = S_HWAIT;
            end
            S_HWAIT: begin
                if (w_adone) begin
                    if (r_last_mul) begin
                        n_p = sce_pkg::OneQ30 + (w_ares >> 16);
                        n_st = S_EXPF;
                    end else begin
                        n_p = {32'd0, sce_pkg::exp_coef(r_k)} + (w_ares >> 16);
                        if (r_k == 3'd0) n_last_mul = 1'b1;
                        else n_k = r_k - 3'd1;
                        n_st = S_HORN;
                    end
                end
            end
            S_EXPF: begin
                w_r = r_p;
                if (r_n >= 9'sd16) w_e = 64'hFFFF_FFFF;
                else if (r_n >= 9'sd14) begin
                    w_e = w_r << r_n[0];
                    if (w_e > 64'hFFFF_FFFF) w_e = 64'hFFFF_FFFF;
                end else if (r_n <= -9'sd49) w_e = 64'd0;
                else w_e = w_r >> 6'(9'sd14 - r_n);
                w_sum = {16'd0, r_esum} + w_e;
                n_esum = (w_sum > sce_pkg::Mask48) ? 48'hFFFF_FFFF_FFFF : w_sum[47:0];
                if ({1'b0, r_item.target_class} == r_col) n_texp = w_e[31:0];
                if (r_col + 9'd1 < w_count) begin
                    n_col = r_col + 9'd1;
                    n_st = S_IDLE;
                end else begin
                    n_lsel = 1'b0;
                    n_st = S_LSTART;
                end
            end
            S_LSTART: begin
                if (r_lsel && r_texp == 32'd0) n_st = S_ROW;
                else begin
                    n_m = (w_k > 6'd30) ? (w_src >> (w_k - 6'd30))
                        : (w_src << (6'd30 - w_k));
                    n_frac = '0; n_i = 5'd0;
                    n_st = S_LSQ;
                end
            end
            S_LSQ: begin
                w_req.start = 1'b1; w_req.op = sce_pkg::OP_MUL;
                w_req.a = r_m; w_req.b = r_m;
                n_st = S_LWAIT;
            end
            S_LWAIT: begin
                if (w_adone) begin
                    w_sq = w_ares >> 30;
                    if (w_sq >= (sce_pkg::OneQ30 << 1)) begin
                        n_m = w_sq >> 1; n_frac = {r_frac[14:0], 1'b1};
                    end else begin
                        n_m = w_sq; n_frac = {r_frac[14:0], 1'b0};
                    end
                    if (r_i == 5'd15) begin
                        w_lv = {w_k, n_frac};
                        if (!r_lsel) begin
                            n_ls = w_lv; n_lsel = 1'b1; n_st = S_LSTART;
                        end else begin
                            n_ls = w_lv; n_st = S_ROW;
                        end
                    end else begin
                        n_i = r_i + 5'd1; n_st = S_LSQ;
                    end
                    // Keep the sum's log while the target's log is formed.
                    if (r_i == 5'd15 && r_lsel) n_ls = r_ls;
                    if (r_i == 5'd15 && r_lsel) n_rb = (r_ls > w_lv) ?
                        32'(r_ls - w_lv) : 32'd0;
                end
            end
            S_ROW: begin
                n_zero = (r_texp == 32'd0);
                if (r_texp == 32'd0) begin
                    n_rb = 32'hFFFF_FFFF; n_ent = 48'hFFFF_FFFF_FFFF;
                end else begin
                    w_ent = {16'd0, r_ent} + {32'd0, r_rb};
                    n_ent = (w_ent > sce_pkg::Mask48) ? 48'hFFFF_FFFF_FFFF : w_ent[47:0];
                end
                n_bpp = 32'd0;
                if (r_item.last_row && r_points != 24'd0) begin
                    w_req.start = 1'b1; w_req.op = sce_pkg::OP_DIV;
                    w_req.a = {16'd0, n_ent}; w_req.b = {40'd0, r_points};
                    n_st = S_DIVW;
                end else begin
                    if (r_item.last_row) n_bpp = 32'hFFFF_FFFF;
                    n_st = S_OUT;
                end
            end
            S_DIVW: begin
                if (w_adone) begin
                    n_bpp = (w_ares[47:32] != 16'd0) ? 32'hFFFF_FFFF : w_ares[31:0];
                    n_st = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ov) begin
                    n_ov = 1'b1;
                    n_out.row_bits = r_rb; n_out.total_bits = r_ent;
                    n_out.bits_per_point = r_bpp;
                    n_out.zero_prob = r_zero; n_out.done_res = r_item.last_row;
                    n_col = '0; n_esum = '0; n_texp = '0;
                    if (r_item.last_row) n_ent = '0;
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ov <= 1'b0; r_col <= '0; r_esum <= '0;
            r_texp <= '0; r_ent <= '0; r_points <= 24'd1; r_classes <= 9'd256;
        end else begin
            r_st <= n_st; r_ov <= n_ov; r_col <= n_col; r_esum <= n_esum;
            r_texp <= n_texp; r_ent <= n_ent;
            if (i_cfg_we && i_cfg_index == sce_pkg::REG_POINTS) r_points <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == sce_pkg::REG_CLASSES)
                r_classes <= i_cfg_data[8:0];
        end
        r_item <= n_item; r_p <= n_p; r_k <= n_k; r_last_mul <= n_last_mul;
        r_n <= n_n; r_f <= n_f; r_m <= n_m; r_frac <= n_frac; r_i <= n_i;
        r_lsel <= n_lsel; r_ls <= n_ls; r_rb <= n_rb; r_zero <= n_zero;
        r_bpp <= n_bpp; r_out <= n_out;
    end

    assign o_in_ready  = (r_st == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    `SCE_ASSERT_IMPLY(a_col_range, i_clk, i_rst_n, 1'b1, r_col < 9'(sce_pkg::MaxClasses))
    `SCE_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_in_valid && o_in_ready, r_st == S_YMUL)
    `SCE_ASSERT_IMPLY(a_zero_saturates, i_clk, i_rst_n, o_out_valid && o_out.zero_prob, o_out.row_bits == 32'hFFFF_FFFF)
endmodule
`default_nettype wire

@@ tb/sce_checker.sv @@
`timescale 1ns / 100ps
`default_nettype none
module sce_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_ready,
    input  wire sce_pkg::t_in  i_in,
    input  wire logic          i_out_valid,
    input  wire logic          i_out_ready,
    input  wire sce_pkg::t_out i_out,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [23:0]   i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_rows_seen
);
    logic [23:0]   points_reg;
    logic [8:0]    classes_reg;
    logic [8:0]    col_idx;
    logic [63:0]   sum_exp;
    logic [63:0]   true_exp;
    logic [63:0]   entropy_acc;
    sce_pkg::t_out row_results[$];

    function automatic logic [63:0] coef(input int k);
        logic [63:0] c;
        case (k)
            0: c = 64'd744261118;
            1: c = 64'd257941248;
            2: c = 64'd59597083;
            3: c = 64'd10327388;
            4: c = 64'd1431680;
            5: c = 64'd165394;
            default: c = 64'd16378;
        endcase
        return c;
    endfunction

    function automatic logic [63:0] fixed_exp(input logic signed [15:0] lg);
        logic signed [63:0] y;
        logic [63:0] yo, f, p, r;
        int n;
        y = 64'(lg) * 64'sd94548 + (64'sd256 <<< 24);
        yo = y;
        n = int'(yo >> 24) - 256;
        f = (yo & 64'hFFFFFF) >> 8;
        p = coef(6);
        for (int k = 5; k >= 0; k--) p = coef(k) + ((p * f) >> 16);
        r = 64'd1073741824 + ((p * f) >> 16);
        if (n >= 16) return 64'hFFFF_FFFF;
        if (n >= 14) begin
            r = r << (n - 14);
            return (r > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : r;
        end
        if (14 - n >= 63) return 64'd0;
        return r >> (14 - n);
    endfunction

    function automatic logic [63:0] fixed_log2(input logic [63:0] v);
        int k;
        logic [63:0] m, frac;
        k = 63;
        frac = '0;
        while (k > 0 && v[k] == 1'b0) k--;
        if (k > 30) m = v >> (k - 30);
        else m = v << (30 - k);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= 64'd2147483648) begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return (64'(k) << 16) | frac;
    endfunction

    task automatic absorb_logit(input sce_pkg::t_in it);
        logic [63:0] e, cnt, ls, lt, rb, bpp;
        sce_pkg::t_out res;
        e = fixed_exp(it.logit);
        cnt = 64'(classes_reg);
        if (cnt == 64'd0) cnt = 64'd1;
        if (cnt > 64'(sce_pkg::MaxClasses)) cnt = 64'(sce_pkg::MaxClasses);
        sum_exp = sum_exp + e;
        if (sum_exp > sce_pkg::Mask48) sum_exp = sce_pkg::Mask48;
        if (64'(it.target_class) == 64'(col_idx)) true_exp = e;
        if (64'(col_idx) + 64'd1 < cnt) begin
            col_idx = col_idx + 9'd1;
            return;
        end
        bpp = '0;
        if (true_exp == 64'd0) begin
            rb = 64'hFFFF_FFFF;
            entropy_acc = sce_pkg::Mask48;
        end else begin
            ls = fixed_log2(sum_exp);
            lt = fixed_log2(true_exp);
            rb = (ls > lt) ? ls - lt : 64'd0;
            entropy_acc = entropy_acc + rb;
            if (entropy_acc > sce_pkg::Mask48) entropy_acc = sce_pkg::Mask48;
        end
        if (it.last_row) begin
            if (points_reg == 24'd0) bpp = 64'hFFFF_FFFF;
            else begin
                bpp = entropy_acc / points_reg;
                if (bpp > 64'hFFFF_FFFF) bpp = 64'hFFFF_FFFF;
            end
        end
        res.row_bits = rb[31:0];
        res.total_bits = entropy_acc[47:0];
        res.bits_per_point = bpp[31:0];
        res.zero_prob = (true_exp == 64'd0);
        res.done_res = it.last_row;
        row_results = {row_results, res};
        col_idx = '0;
        sum_exp = '0;
        true_exp = '0;
        if (it.last_row) entropy_acc = '0;
    endtask

    always @(posedge i_clk) begin
        sce_pkg::t_out want;
        if (!i_rst_n) begin
            points_reg = 24'd1;
            classes_reg = 9'd256;
            col_idx = '0;
            sum_exp = '0;
            true_exp = '0;
            entropy_acc = '0;
            row_results.delete();
            o_fail_count = 0;
            o_rows_seen = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == sce_pkg::REG_POINTS) points_reg = i_cfg_data;
                else if (i_cfg_index == sce_pkg::REG_CLASSES) classes_reg = i_cfg_data[8:0];
            end
            if (i_out_valid && i_out_ready) begin
                o_rows_seen++;
                if (row_results.size() == 0) begin
                    $error("unexpected result transaction");
                    o_fail_count++;
                end else begin
                    want = row_results.pop_front();
                    if (want.row_bits !== i_out.row_bits) begin
                        $error("row_bits exp %h got %h", want.row_bits, i_out.row_bits);
                        o_fail_count++;
                    end
                    if (want.total_bits !== i_out.total_bits) begin
                        $error("total_bits exp %h got %h", want.total_bits,
                               i_out.total_bits);
                        o_fail_count++;
                    end
                    if (want.bits_per_point !== i_out.bits_per_point) begin
                        $error("bits_per_point exp %h got %h", want.bits_per_point,
                               i_out.bits_per_point);
                        o_fail_count++;
                    end
                    if (want.zero_prob !== i_out.zero_prob) begin
                        $error("zero_prob exp %b got %b", want.zero_prob, i_out.zero_prob);
                        o_fail_count++;
                    end
                    if (want.done_res !== i_out.done_res) begin
                        $error("done_res exp %b got %b", want.done_res, i_out.done_res);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) absorb_logit(i_in);
        end
        o_pending = row_results.size();
    end
endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb;
    logic          clk = 0;
    logic          rst_n = 0;
    logic          in_valid = 0;
    logic          in_ready;
    sce_pkg::t_in  in_item = '0;
    logic          out_valid;
    logic          out_ready = 0;
    sce_pkg::t_out out_item;
    logic          cfg_we = 0;
    logic [1:0]    cfg_index = '0;
    logic [23:0]   cfg_data = '0;
    int            fail_count;
    int            pending;
    int            rows_seen;
    int            send_idle = 0;
    int            recv_idle = 0;
    bit            recv_hold = 0;
    int            stall_cycles = 0;
    int            items_sent = 0;
    int            class_now = 256;
    int            row_col = 0;
    logic [7:0]    row_target = '0;

    always begin
        #5 clk = 1;
        #5 clk = 0;
    end

    softmax_cross_entropy_bpp DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out(out_item),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    sce_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in(in_item),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out(out_item),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_rows_seen(rows_seen)
    );

    always @(negedge clk) begin
        if (recv_hold) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 20000) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_item(input logic signed [15:0] lg, input logic [7:0] tc,
                             input logic last);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_item <= '{logit: lg, target_class: tc, last_row: last};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        if (idx == sce_pkg::REG_CLASSES) begin
            class_now = (val[8:0] == 0) ? 1 : (val[8:0] > 256 ? 256 : val[8:0]);
        end
    endtask

    task automatic random_logit(output logic signed [15:0] lg);
        case ($urandom_range(3))
            0: lg = 16'($urandom);
            1: lg = 16'($urandom_range(2047) - 1024);
            2: lg = ($urandom_range(1)) ? 16'sh7FFF : -16'sh8000;
            default: lg = 16'($urandom_range(1023));
        endcase
    endtask

    task automatic random_phase(input int n_items);
        logic signed [15:0] lg;
        logic [7:0] tc;
        for (int i = 0; i < n_items; i++) begin
            if (row_col == 0) begin
                row_target = ($urandom_range(9) == 0) ? 8'($urandom) :
                             8'($urandom_range(class_now - 1));
            end
            tc = ($urandom_range(19) == 0) ? 8'($urandom) : row_target;
            random_logit(lg);
            row_col++;
            if (row_col >= class_now) row_col = 0;
            send_item(lg, tc, (row_col == 0) ? ($urandom_range(2) == 0) :
                      1'($urandom_range(1)));
        end
    endtask

    task automatic finish_row();
        while (row_col != 0) begin
            row_col++;
            if (row_col >= class_now) row_col = 0;
            send_item(16'($urandom_range(511)), row_target, 1'b1);
        end
    endtask

    initial begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_reg(sce_pkg::REG_CLASSES, 24'd2);
        write_reg(sce_pkg::REG_POINTS, 24'd1);
        send_item(16'sh7FFF, 8'd0, 1'b0);
        send_item(-16'sh8000, 8'd0, 1'b0);
        send_item(-16'sh8000, 8'd1, 1'b0);
        send_item(16'sh0000, 8'd1, 1'b1);
        send_item(16'sh0100, 8'd255, 1'b0);
        send_item(16'sh0200, 8'd255, 1'b1);
        send_item(16'sh7FFF, 8'd1, 1'b0);
        send_item(16'sh7FFF, 8'd1, 1'b1);
        drain();
        write_reg(sce_pkg::REG_POINTS, 24'd0);
        write_reg(sce_pkg::REG_CLASSES, 24'd1);
        send_item(16'sh0000, 8'd0, 1'b1);
        send_item(-16'sh0800, 8'd0, 1'b1);
        send_item(16'sh1234, 8'd128, 1'b1);
        drain();
        write_reg(sce_pkg::REG_POINTS, 24'hFFFFFF);
        write_reg(sce_pkg::REG_CLASSES, 24'h1FF);
        send_idle = 6;
        recv_idle = 53;
        random_phase(256);
        finish_row();
        drain();
        write_reg(sce_pkg::REG_CLASSES, 24'd0);
        write_reg(sce_pkg::REG_POINTS, 24'd3);
        random_phase(30);
        drain();
        write_reg(sce_pkg::REG_CLASSES, 24'd4);
        write_reg(sce_pkg::REG_POINTS, 24'h800000);
        send_idle = 53;
        recv_idle = 6;
        random_phase(200);
        finish_row();
        drain();
        write_reg(sce_pkg::REG_CLASSES, 24'd3);
        write_reg(sce_pkg::REG_POINTS, 24'd7);
        send_idle = 0;
        recv_idle = 0;
        recv_hold = 1;
        fork
            begin
                repeat (3000) @(negedge clk);
                recv_hold = 0;
            end
            random_phase(30);
        join
        random_phase(400);
        finish_row();
        drain();
        $display("tb: %0d logit transactions sent, %0d row results checked", items_sent,
                 rows_seen);
        $display("tb: class counts 1 to 256 and point counts 0 to max exercised");
        if (fail_count == 0 && pending == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/sce_pkg.sv
rtl/sce_alu.sv
rtl/softmax_cross_entropy_bpp.sv
tb/sce_checker.sv
tb/tb.sv
